// ===== rtl/dsa_pkg.sv =====
// shared types and codes of the double-ended stack allocator
// request/result structs, command and status codes, stack control structs
// no dependencies
package dsa_pkg;

	localparam int VAL_W = 21;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [VAL_W:0]   wide_t;

	typedef logic [2:0] cmd_t;
	typedef logic [2:0] status_t;

	// command codes
	localparam cmd_t CMD_ALLOC_LOWER = 3'd0;
	localparam cmd_t CMD_ALLOC_UPPER = 3'd1;
	localparam cmd_t CMD_FREE_LOWER  = 3'd2;
	localparam cmd_t CMD_FREE_UPPER  = 3'd3;
	localparam cmd_t CMD_CLEAR       = 3'd4;

	// status codes
	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_ZERO     = 3'd1;
	localparam status_t ST_NOROOM   = 3'd2;
	localparam status_t ST_FULL     = 3'd3;
	localparam status_t ST_RANGE    = 3'd4;
	localparam status_t ST_MISMATCH = 3'd5;

	localparam val_t ARENA_RESET = 21'h100000;

	typedef struct packed {
		cmd_t command;
		val_t amount;
	} req_t;

	typedef struct packed {
		val_t    block_offset;
		val_t    lower_top;
		val_t    upper_top;
		status_t status;
	} rsp_t;

	// control into one mark stack
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stk_ctl_t;

	// status out of one mark stack
	typedef struct packed {
		logic empty;
		logic full;
		val_t top;
	} stk_stat_t;

	// shared add/subtract unit
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

endpackage

// ===== rtl/dsa_alu.sv =====
// shared add/subtract and compare unit of the allocator
// depends on dsa_pkg
module dsa_alu (
	input  dsa_pkg::alu_op_t op,
	input  dsa_pkg::wide_t   a,
	input  dsa_pkg::wide_t   b,
	output dsa_pkg::wide_t   res,
	output logic             lt,
	output logic             eq
);
	import dsa_pkg::*;

	logic [VAL_W+1:0] full_res;

	// one adder, borrow gives the less-than flag
	always_comb begin
		if (op == ALU_ADD) begin
			full_res = {1'b0, a} + {1'b0, b};
		end else begin
			full_res = {1'b0, a} - {1'b0, b};
		end
	end

	assign res = full_res[VAL_W:0];
	assign lt  = (op == ALU_SUB) && full_res[VAL_W+1];
	assign eq  = (op == ALU_SUB) && (full_res == '0);

endmodule

// ===== rtl/dsa_stack.sv =====
// one stack of boundary marks: mark memory, fill count and cached top
// depends on dsa_pkg
module dsa_stack #(
	parameter int MARK_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dsa_pkg::stk_ctl_t   ctl,
	input  dsa_pkg::val_t       wdata,
	output dsa_pkg::stk_stat_t  stat
);
	import dsa_pkg::*;

	localparam int IDX_W = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
	localparam int CNT_W = $clog2(MARK_DEPTH + 1);

	val_t             mem [MARK_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_ptr;
	logic             pend_q;
	val_t             top_q;
	val_t             rd_q;

	// entry below the current top, fetched when popping
	assign rd_ptr = cnt_q - CNT_W'(2);

	// mark memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[cnt_q[IDX_W-1:0]] <= wdata;
		end
		if (ctl.pop && (cnt_q > CNT_W'(1))) begin
			rd_q <= mem[rd_ptr[IDX_W-1:0]];
		end
	end

	// fill count and pending-read flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= ctl.pop;
			if (ctl.clear) begin
				cnt_q <= '0;
			end else if (ctl.push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (ctl.pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// cached top of stack, reloaded from rd_q when pend_q is set after a pop
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			top_q <= wdata;
		end else if (pend_q) begin
			top_q <= rd_q;
		end
	end

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNT_W'(MARK_DEPTH));
	assign stat.top   = top_q;

	// checks
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !stat.full) else $error("push onto full mark stack");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !stat.empty) else $error("pop from empty mark stack");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.push && ctl.pop)) else $error("push and pop together");
	a_no_pop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !ctl.pop && !ctl.push) else $error("stack op while top settles");

endmodule

// ===== rtl/double_ended_stack_allocator_unit.sv =====
// top level of the double-ended stack allocator: sequencer around one shared alu
// depends on dsa_pkg, dsa_alu, dsa_stack
//
// channel  | signals                     | handshake
// request  | req                         | taken when start && !busy
// result   | rsp                         | valid while done is high, one cycle
// config   | cfg_data                    | written when cfg_valid && cfg_ready
//
// accepted request to result strobe: clear, unused codes and zero size go from
// check to response; alloc-lower runs check, sum, room; alloc-upper adds an
// upper offset step unless it fails on room or a full stack; free runs range,
// then, if in range, pop check and a mark-read wait plus pop check per pop.
// busy stays high from acceptance until the result strobe; a new request can
// be taken in the strobe cycle. reset empties both stacks, arena_size resets
// to 1048576. the result receiver cannot stall; cfg_ready is low while busy.
module double_ended_stack_allocator_unit #(
	parameter int MARK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dsa_pkg::req_t     req,
	output logic              done,
	output dsa_pkg::rsp_t     rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  dsa_pkg::val_t     cfg_data
);
	import dsa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_SUM,
		S_ROOM,
		S_UPOFF,
		S_RANGE,
		S_POPCHK,
		S_POPWAIT,
		S_RESP
	} state_t;

	state_t    state_q;
	cmd_t      cmd_q;
	val_t      amt_q;
	val_t      arena_q;
	wide_t     t_q;
	val_t      offset_q;
	status_t   status_q;
	logic      done_q;
	rsp_t      rsp_q;

	stk_ctl_t  lo_ctl;
	stk_ctl_t  up_ctl;
	stk_stat_t lo_stat;
	stk_stat_t up_stat;
	val_t      push_data;
	val_t      lo_eff;
	val_t      hi_eff;

	alu_op_t   alu_op;
	wide_t     alu_a;
	wide_t     alu_b;
	wide_t     alu_res;
	logic      alu_lt;
	logic      alu_eq;
	logic      is_lower;

	// mark stacks
	dsa_stack #(.MARK_DEPTH(MARK_DEPTH)) u_lower (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (lo_ctl),
		.wdata (push_data),
		.stat  (lo_stat)
	);

	dsa_stack #(.MARK_DEPTH(MARK_DEPTH)) u_upper (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (up_ctl),
		.wdata (push_data),
		.stat  (up_stat)
	);

	dsa_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.res(alu_res),
		.lt (alu_lt),
		.eq (alu_eq)
	);

	// effective tops, empty stacks read as arena bounds
	assign lo_eff   = lo_stat.empty ? '0 : lo_stat.top;
	assign hi_eff   = up_stat.empty ? arena_q : up_stat.top;
	assign is_lower = (cmd_q == CMD_ALLOC_LOWER) || (cmd_q == CMD_FREE_LOWER);

	// operand selection for the shared alu
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_SUM: begin
				alu_op = ALU_ADD;
				alu_a  = {1'b0, lo_eff};
				alu_b  = {1'b0, amt_q};
			end
			S_ROOM: begin
				alu_a = t_q;
				alu_b = {1'b0, hi_eff};
			end
			S_UPOFF: begin
				alu_a = {1'b0, hi_eff};
				alu_b = {1'b0, amt_q};
			end
			S_RANGE: begin
				alu_a = {1'b0, amt_q};
				alu_b = {1'b0, arena_q};
			end
			S_POPCHK: begin
				if (is_lower) begin
					alu_a = {1'b0, amt_q};
					alu_b = {1'b0, lo_eff};
				end else begin
					alu_a = {1'b0, hi_eff};
					alu_b = {1'b0, amt_q};
				end
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	// stack control
	always_comb begin
		lo_ctl    = '0;
		up_ctl    = '0;
		push_data = alu_res[VAL_W-1:0];
		case (state_q)
			S_CHK: begin
				if (cmd_q == CMD_CLEAR) begin
					lo_ctl.clear = 1'b1;
					up_ctl.clear = 1'b1;
				end
			end
			S_ROOM: begin
				push_data = t_q[VAL_W-1:0];
				if (alu_lt && !lo_stat.full && is_lower) begin
					lo_ctl.push = 1'b1;
				end
			end
			S_UPOFF: begin
				up_ctl.push = 1'b1;
			end
			S_POPCHK: begin
				if (alu_lt) begin
					lo_ctl.pop = is_lower;
					up_ctl.pop = !is_lower;
				end
			end
			default: begin
				lo_ctl = '0;
			end
		endcase
	end

	// sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			arena_q <= ARENA_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				arena_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= req.command;
						amt_q    <= req.amount;
						offset_q <= '0;
						status_q <= ST_OK;
						state_q  <= S_CHK;
					end
				end
				S_CHK: begin
					if ((cmd_q == CMD_ALLOC_LOWER) || (cmd_q == CMD_ALLOC_UPPER)) begin
						if (amt_q == '0) begin
							status_q <= ST_ZERO;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_SUM;
						end
					end else if ((cmd_q == CMD_FREE_LOWER) || (cmd_q == CMD_FREE_UPPER)) begin
						state_q <= S_RANGE;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SUM: begin
					t_q     <= alu_res;
					state_q <= S_ROOM;
				end
				S_ROOM: begin
					if (!alu_lt) begin
						status_q <= ST_NOROOM;
						state_q  <= S_RESP;
					end else if (is_lower ? lo_stat.full : up_stat.full) begin
						status_q <= ST_FULL;
						state_q  <= S_RESP;
					end else if (is_lower) begin
						offset_q <= lo_eff;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_UPOFF;
					end
				end
				S_UPOFF: begin
					offset_q <= alu_res[VAL_W-1:0];
					state_q  <= S_RESP;
				end
				S_RANGE: begin
					if (!alu_lt) begin
						status_q <= ST_RANGE;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_POPCHK;
					end
				end
				S_POPCHK: begin
					if (alu_lt) begin
						state_q <= S_POPWAIT;
					end else begin
						status_q <= alu_eq ? ST_OK : ST_MISMATCH;
						state_q  <= S_RESP;
					end
				end
				S_POPWAIT: begin
					state_q <= S_POPCHK;
				end
				S_RESP: begin
					rsp_q.block_offset <= offset_q;
					rsp_q.lower_top    <= lo_eff;
					rsp_q.upper_top    <= hi_eff;
					rsp_q.status       <= status_q;
					done_q             <= 1'b1;
					state_q            <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// checks
	a_done_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_RESP)) else $error("result strobe without response step");
	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request taken but not busy");
	a_popwait_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POPWAIT) |-> $past(lo_ctl.pop || up_ctl.pop))
		else $error("pop wait without a pop");

endmodule
